[hdl/obpl_pkg.sv]
`default_nettype none

package obpl_pkg;

  localparam int DEPTH      = 32;
  localparam int PRICE_BITS = 40;
  localparam int QTY_BITS   = 40;
  localparam int UID_W      = 48;
  localparam int RC_W       = 6;
  localparam int MAX_RES    = 32;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int N_W   = (CNT_W > RC_W) ? CNT_W : RC_W;

  typedef enum logic [1:0] {
    MODE_RESET = 2'd0,
    MODE_SNAP  = 2'd1,
    MODE_DIFF  = 2'd2,
    MODE_READ  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_PUT   = 2'd1,
    OP_ERASE = 2'd2,
    OP_CLEAR = 2'd3
  } cell_op_e;

  typedef struct packed {
    cell_op_e              op;
    logic [PRICE_BITS-1:0] price;
    logic [QTY_BITS-1:0]   qty;
  } cmd_t;

  typedef struct packed {
    logic                  valid;
    logic [PRICE_BITS-1:0] price;
    logic [QTY_BITS-1:0]   qty;
  } lvl_t;

endpackage

`default_nettype wire

[hdl/obpl_cell.sv]
`default_nettype none

module obpl_cell
  import obpl_pkg::*;
(
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  ask_i,
  input  cmd_t cmd_i,
  input  wire  hit_i,
  input  lvl_t left_i,
  input  wire  left_better_i,
  input  wire  left_found_i,
  input  lvl_t right_i,
  output lvl_t lvl_o,
  output logic match_o,
  output logic better_o,
  output logic found_o
);

  logic                  valid_q, valid_d;
  logic [PRICE_BITS-1:0] price_q, price_d;
  logic [QTY_BITS-1:0]   qty_q, qty_d;

  always_comb begin
    match_o  = valid_q && (price_q == cmd_i.price);
    better_o = !valid_q || (ask_i ? (cmd_i.price < price_q) : (cmd_i.price > price_q));
    found_o  = left_found_i || match_o;
    valid_d  = valid_q;
    price_d  = price_q;
    qty_d    = qty_q;
    case (cmd_i.op)
      OP_PUT: begin
        if (hit_i) begin
          if (match_o) begin
            qty_d = cmd_i.qty;
          end
        end else if (left_better_i) begin
          valid_d = left_i.valid;
          price_d = left_i.price;
          qty_d   = left_i.qty;
        end else if (better_o) begin
          valid_d = 1'b1;
          price_d = cmd_i.price;
          qty_d   = cmd_i.qty;
        end
      end
      OP_ERASE: begin
        if (found_o) begin
          valid_d = right_i.valid;
          price_d = right_i.price;
          qty_d   = right_i.qty;
        end
      end
      OP_CLEAR: begin
        valid_d = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    price_q <= price_d;
    qty_q   <= qty_d;
  end

  assign lvl_o.valid = valid_q;
  assign lvl_o.price = price_q;
  assign lvl_o.qty   = qty_q;

endmodule

`default_nettype wire

[hdl/obpl_side.sv]
`default_nettype none

module obpl_side
  import obpl_pkg::*;
(
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    ask_i,
  input  cmd_t                   cmd_i,
  input  wire  [IDX_W-1:0]       rd_idx_i,
  output logic [PRICE_BITS-1:0]  rd_price_o,
  output logic [QTY_BITS-1:0]    rd_qty_o,
  output logic [CNT_W-1:0]       count_o,
  output logic                   ovf_o
);

  lvl_t             lvl [DEPTH];
  logic [DEPTH-1:0] match;
  logic [DEPTH-1:0] better;
  logic [DEPTH-1:0] found;
  logic [DEPTH-1:0] valid_vec;
  logic             hit;
  logic             full;
  logic [CNT_W-1:0] count_q, count_d;

  assign hit  = |match;
  assign full = lvl[DEPTH-1].valid;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    lvl_t left;
    lvl_t right;
    logic left_better;
    logic left_found;

    if (i == 0) begin : g_head
      assign left        = '0;
      assign left_better = 1'b0;
      assign left_found  = 1'b0;
    end else begin : g_body
      assign left        = lvl[i-1];
      assign left_better = better[i-1];
      assign left_found  = found[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right = '0;
    end else begin : g_next
      assign right = lvl[i+1];
    end

    obpl_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ask_i         (ask_i),
      .cmd_i         (cmd_i),
      .hit_i         (hit),
      .left_i        (left),
      .left_better_i (left_better),
      .left_found_i  (left_found),
      .right_i       (right),
      .lvl_o         (lvl[i]),
      .match_o       (match[i]),
      .better_o      (better[i]),
      .found_o       (found[i])
    );

    assign valid_vec[i] = lvl[i].valid;
  end

  always_comb begin
    count_d = count_q;
    case (cmd_i.op)
      OP_PUT: begin
        if (!hit && !full) begin
          count_d = count_q + CNT_W'(1);
        end
      end
      OP_ERASE: begin
        if (hit) begin
          count_d = count_q - CNT_W'(1);
        end
      end
      OP_CLEAR: begin
        count_d = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign ovf_o      = (cmd_i.op == OP_PUT) && !hit && full;
  assign count_o    = count_q;
  assign rd_price_o = lvl[rd_idx_i].price;
  assign rd_qty_o   = lvl[rd_idx_i].qty;

`ifndef NO_ASSERTIONS
  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) == 32'($countones(valid_vec)))
    else $error("level count disagrees with occupied cells");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= 32'(DEPTH))
    else $error("level count above depth");
`endif

endmodule

`default_nettype wire

[hdl/order_book_price_levels_top.sv]
// order book price level table, bid and ask sides of up to DEPTH levels each
//
// input channel: in_valid_i / in_ready_o, one transfer per command
// (reset, snapshot level, diff level or read). output channel:
// out_valid_o / out_ready_i, one transfer per result, last_result_o marks
// the final result of a command.
//
// each side is a chain of cells kept sorted best first; an insert, overwrite
// or erase is applied to all cells of the chain in the same cycle by neighbor
// shifts. a command is captured into the op registers and applied in S_EXEC
// once the output register is free, a snapshot level with first set clearing
// both sides there first. reset, snapshot and diff commands load a status
// result into the output register when applied; the next command is taken
// only once the block is back in S_IDLE. a read of n levels moves to S_READ
// and presents one level per cycle while the output register is free.
//
// reset empties both sides and clears the book valid and overflow flags.
// while the receiver stalls the result stays in the output register and the
// block holds its work until that register is free.
`default_nettype none

module order_book_price_levels_top
  import obpl_pkg::*;
(
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_ready_o,
  input  wire  [1:0]            mode_i,
  input  wire                   side_i,
  input  wire  [PRICE_BITS-1:0] price_i,
  input  wire  [QTY_BITS-1:0]   qty_i,
  input  wire                   first_i,
  input  wire                   last_i,
  input  wire  [UID_W-1:0]      update_id_i,
  input  wire  [RC_W-1:0]       read_count_i,
  output logic                  out_valid_o,
  input  wire                   out_ready_i,
  output logic                  out_side_o,
  output logic [PRICE_BITS-1:0] out_price_o,
  output logic [QTY_BITS-1:0]   out_qty_o,
  output logic                  level_valid_o,
  output logic                  book_valid_o,
  output logic [UID_W-1:0]      cur_update_id_o,
  output logic                  overflow_o,
  output logic                  last_result_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_READ = 2'd2
  } state_e;

  state_e                state_q;
  mode_e                 op_mode_q;
  logic                  op_side_q;
  logic [PRICE_BITS-1:0] op_price_q;
  logic [QTY_BITS-1:0]   op_qty_q;
  logic                  op_first_q;
  logic                  op_last_q;
  logic [UID_W-1:0]      op_uid_q;
  logic [RC_W-1:0]       op_rc_q;

  logic                  book_valid_q, book_valid_d;
  logic [UID_W-1:0]      uid_q, uid_d;
  logic                  ovf_q, ovf_d;
  logic [N_W-1:0]        n_q;
  logic [IDX_W-1:0]      rd_idx_q;

  logic                  out_valid_q;
  logic                  out_side_q;
  logic [PRICE_BITS-1:0] out_price_q;
  logic [QTY_BITS-1:0]   out_qty_q;
  logic                  level_valid_q;
  logic                  book_valid_out_q;
  logic [UID_W-1:0]      uid_out_q;
  logic                  ovf_out_q;
  logic                  last_out_q;

  cmd_t                  bid_cmd, ask_cmd, side_cmd;
  logic [PRICE_BITS-1:0] bid_rd_price, ask_rd_price, rd_price;
  logic [QTY_BITS-1:0]   bid_rd_qty, ask_rd_qty, rd_qty;
  logic [CNT_W-1:0]      bid_count, ask_count;
  logic                  bid_ovf, ask_ovf;

  logic                  out_free;
  logic                  out_load;
  logic                  exec_clear;
  logic                  exec_fire;
  logic                  read_fire;
  logic [RC_W-1:0]       rc_sat;
  logic [N_W-1:0]        side_cnt;
  logic [N_W-1:0]        n_calc;
  logic                  rd_last;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);
  assign exec_clear = (state_q == S_EXEC) && (op_mode_q == MODE_SNAP) && op_first_q;
  assign exec_fire  = (state_q == S_EXEC) && !exec_clear && out_free;
  assign read_fire  = (state_q == S_READ) && out_free;
  assign out_load   = read_fire ||
                      (exec_fire && !((op_mode_q == MODE_READ) && (n_calc != '0)));

  assign rc_sat   = (op_rc_q > RC_W'(MAX_RES)) ? RC_W'(MAX_RES) : op_rc_q;
  assign side_cnt = op_side_q ? N_W'(ask_count) : N_W'(bid_count);
  assign n_calc   = (side_cnt < N_W'(rc_sat)) ? side_cnt : N_W'(rc_sat);
  assign rd_last  = (N_W'(rd_idx_q) + N_W'(1)) == n_q;
  assign rd_price = op_side_q ? ask_rd_price : bid_rd_price;
  assign rd_qty   = op_side_q ? ask_rd_qty : bid_rd_qty;

  always_comb begin
    side_cmd.op    = OP_NONE;
    side_cmd.price = op_price_q;
    side_cmd.qty   = op_qty_q;
    book_valid_d   = book_valid_q;
    uid_d          = uid_q;
    if (exec_fire) begin
      case (op_mode_q)
        MODE_SNAP: begin
          if (op_qty_q != '0) begin
            side_cmd.op = OP_PUT;
          end
          if (op_last_q) begin
            uid_d        = op_uid_q;
            book_valid_d = 1'b1;
          end
        end
        MODE_DIFF: begin
          if (book_valid_q) begin
            side_cmd.op = (op_qty_q == '0) ? OP_ERASE : OP_PUT;
            if (op_last_q) begin
              uid_d = op_uid_q;
            end
          end
        end
        MODE_RESET: begin
          book_valid_d = 1'b0;
          uid_d        = '0;
        end
        default: begin
        end
      endcase
    end

    bid_cmd = side_cmd;
    ask_cmd = side_cmd;
    if (op_side_q) begin
      bid_cmd.op = OP_NONE;
    end else begin
      ask_cmd.op = OP_NONE;
    end
    if (exec_clear || (exec_fire && (op_mode_q == MODE_RESET))) begin
      bid_cmd.op = OP_CLEAR;
      ask_cmd.op = OP_CLEAR;
    end

    ovf_d = ovf_q || (op_side_q ? ask_ovf : bid_ovf);
    if (exec_fire && (op_mode_q == MODE_RESET)) begin
      ovf_d = 1'b0;
    end
  end

  obpl_side u_bid (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ask_i      (1'b0),
    .cmd_i      (bid_cmd),
    .rd_idx_i   (rd_idx_q),
    .rd_price_o (bid_rd_price),
    .rd_qty_o   (bid_rd_qty),
    .count_o    (bid_count),
    .ovf_o      (bid_ovf)
  );

  obpl_side u_ask (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ask_i      (1'b1),
    .cmd_i      (ask_cmd),
    .rd_idx_i   (rd_idx_q),
    .rd_price_o (ask_rd_price),
    .rd_qty_o   (ask_rd_qty),
    .count_o    (ask_count),
    .ovf_o      (ask_ovf)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= S_IDLE;
      op_mode_q        <= MODE_RESET;
      op_side_q        <= 1'b0;
      op_price_q       <= '0;
      op_qty_q         <= '0;
      op_first_q       <= 1'b0;
      op_last_q        <= 1'b0;
      op_uid_q         <= '0;
      op_rc_q          <= '0;
      book_valid_q     <= 1'b0;
      uid_q            <= '0;
      ovf_q            <= 1'b0;
      n_q              <= '0;
      rd_idx_q         <= '0;
      out_valid_q      <= 1'b0;
      out_side_q       <= 1'b0;
      out_price_q      <= '0;
      out_qty_q        <= '0;
      level_valid_q    <= 1'b0;
      book_valid_out_q <= 1'b0;
      uid_out_q        <= '0;
      ovf_out_q        <= 1'b0;
      last_out_q       <= 1'b0;
    end else begin
      book_valid_q <= book_valid_d;
      uid_q        <= uid_d;
      ovf_q        <= ovf_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            op_mode_q  <= mode_e'(mode_i);
            op_side_q  <= side_i;
            op_price_q <= price_i;
            op_qty_q   <= qty_i;
            op_first_q <= first_i;
            op_last_q  <= last_i;
            op_uid_q   <= update_id_i;
            op_rc_q    <= read_count_i;
            state_q    <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (exec_clear) begin
            op_first_q <= 1'b0;
          end else if (exec_fire) begin
            if ((op_mode_q == MODE_READ) && (n_calc != '0)) begin
              n_q      <= n_calc;
              rd_idx_q <= '0;
              state_q  <= S_READ;
            end else begin
              out_side_q       <= op_side_q;
              out_price_q      <= '0;
              out_qty_q        <= '0;
              level_valid_q    <= 1'b0;
              book_valid_out_q <= book_valid_d;
              uid_out_q        <= uid_d;
              ovf_out_q        <= ovf_d;
              last_out_q       <= 1'b1;
              state_q          <= S_IDLE;
            end
          end
        end
        S_READ: begin
          if (read_fire) begin
            out_side_q       <= op_side_q;
            out_price_q      <= rd_price;
            out_qty_q        <= rd_qty;
            level_valid_q    <= 1'b1;
            book_valid_out_q <= book_valid_q;
            uid_out_q        <= uid_q;
            ovf_out_q        <= ovf_q;
            last_out_q       <= rd_last;
            rd_idx_q         <= rd_idx_q + IDX_W'(1);
            if (rd_last) begin
              state_q <= S_IDLE;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_side_o      = out_side_q;
  assign out_price_o     = out_price_q;
  assign out_qty_o       = out_qty_q;
  assign level_valid_o   = level_valid_q;
  assign book_valid_o    = book_valid_out_q;
  assign cur_update_id_o = uid_out_q;
  assign overflow_o      = ovf_out_q;
  assign last_result_o   = last_out_q;

`ifndef NO_ASSERTIONS
  a_book_valid_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(book_valid_q) |-> $past(op_mode_q == MODE_RESET))
    else $error("book valid dropped without a reset command");

  a_read_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> (N_W'(rd_idx_q) < n_q))
    else $error("read index beyond requested level count");

  a_read_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    read_fire |=> (out_valid_o && level_valid_o))
    else $error("read step did not present a level");
`endif

endmodule

`default_nettype wire

[tb/sv/order_book_price_levels_checker.sv]
module order_book_price_levels_checker
  import obpl_pkg::*;
(
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  input  wire                   in_ready_i,
  input  wire  [1:0]            mode_i,
  input  wire                   side_i,
  input  wire  [PRICE_BITS-1:0] price_i,
  input  wire  [QTY_BITS-1:0]   qty_i,
  input  wire                   first_i,
  input  wire                   last_i,
  input  wire  [UID_W-1:0]      update_id_i,
  input  wire  [RC_W-1:0]       read_count_i,
  input  wire                   out_valid_i,
  input  wire                   out_ready_i,
  input  wire                   out_side_i,
  input  wire  [PRICE_BITS-1:0] out_price_i,
  input  wire  [QTY_BITS-1:0]   out_qty_i,
  input  wire                   level_valid_i,
  input  wire                   book_valid_i,
  input  wire  [UID_W-1:0]      cur_update_id_i,
  input  wire                   overflow_i,
  input  wire                   last_result_i,
  output int                    fail_cnt_o,
  output int                    pending_o,
  output int                    checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                  side;
    logic [PRICE_BITS-1:0] price;
    logic [QTY_BITS-1:0]   qty;
    logic                  level_valid;
    logic                  book_valid;
    logic [UID_W-1:0]      update_id;
    logic                  overflow;
    logic                  last_result;
  } book_result_t;

  book_result_t expected_q[$];
  book_result_t want;

  logic [PRICE_BITS-1:0] book_px  [2][DEPTH];
  logic [QTY_BITS-1:0]   book_qty [2][DEPTH];
  int                    book_cnt [2];
  logic [UID_W-1:0]      book_uid;
  logic                  book_live;
  logic                  book_ovf;

  function automatic bit better_price(int s, logic [PRICE_BITS-1:0] a,
                                      logic [PRICE_BITS-1:0] b);
    return s ? (a < b) : (a > b);
  endfunction

  function automatic void clear_sides();
    for (int s = 0; s < 2; s++) begin
      for (int i = 0; i < DEPTH; i++) begin
        book_px[s][i]  = '0;
        book_qty[s][i] = '0;
      end
      book_cnt[s] = 0;
    end
  endfunction

  function automatic void put_level(int s, logic [PRICE_BITS-1:0] p,
                                    logic [QTY_BITS-1:0] q);
    int n;
    int pos;
    int i;
    n = book_cnt[s];
    pos = n;
    for (i = 0; i < n; i++) begin
      if (book_px[s][i] == p) begin
        book_qty[s][i] = q;
        return;
      end
      if (better_price(s, p, book_px[s][i])) begin
        pos = i;
        break;
      end
    end
    if (n >= DEPTH) begin
      book_ovf = 1'b1;
      if (pos >= DEPTH) return;
      n = DEPTH - 1;
    end
    for (i = n; i > pos; i--) begin
      book_px[s][i]  = book_px[s][i-1];
      book_qty[s][i] = book_qty[s][i-1];
    end
    book_px[s][pos]  = p;
    book_qty[s][pos] = q;
    if (book_cnt[s] < DEPTH) book_cnt[s] = n + 1;
  endfunction

  function automatic void erase_level(int s, logic [PRICE_BITS-1:0] p);
    int n;
    int i;
    n = book_cnt[s];
    for (i = 0; i < n; i++) begin
      if (book_px[s][i] == p) break;
    end
    if (i >= n) return;
    for (; i + 1 < n; i++) begin
      book_px[s][i]  = book_px[s][i+1];
      book_qty[s][i] = book_qty[s][i+1];
    end
    book_px[s][n-1]  = '0;
    book_qty[s][n-1] = '0;
    book_cnt[s] = n - 1;
  endfunction

  function automatic void push_result(int s, logic [PRICE_BITS-1:0] p,
                                      logic [QTY_BITS-1:0] q, logic lv, logic lr);
    book_result_t r;
    r.side        = s[0];
    r.price       = p;
    r.qty         = q;
    r.level_valid = lv;
    r.book_valid  = book_live;
    r.update_id   = book_uid;
    r.overflow    = book_ovf;
    r.last_result = lr;
    expected_q.push_back(r);
  endfunction

  // apply one accepted command and queue what it should produce
  function automatic void apply_command();
    int s;
    int n;
    int lim;
    s = side_i;
    n = 0;
    case (mode_e'(mode_i))
      MODE_RESET: begin
        clear_sides();
        book_uid  = '0;
        book_live = 1'b0;
        book_ovf  = 1'b0;
      end
      MODE_SNAP: begin
        if (first_i) clear_sides();
        if (qty_i != '0) put_level(s, price_i, qty_i);
        if (last_i) begin
          book_uid  = update_id_i;
          book_live = 1'b1;
        end
      end
      MODE_DIFF: begin
        if (book_live) begin
          if (qty_i == '0) erase_level(s, price_i);
          else put_level(s, price_i, qty_i);
          if (last_i) book_uid = update_id_i;
        end
      end
      default: begin
        n = book_cnt[s];
        lim = read_count_i;
        if (lim > MAX_RES) lim = MAX_RES;
        if (lim < n) n = lim;
        for (int i = 0; i < n; i++)
          push_result(s, book_px[s][i], book_qty[s][i], 1'b1, i == n - 1);
      end
    endcase
    if (n == 0) push_result(s, '0, '0, 1'b0, 1'b1);
  endfunction

  function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      fail_cnt_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_sides();
      book_uid  = '0;
      book_live = 1'b0;
      book_ovf  = 1'b0;
      expected_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        checked_o++;
        if (expected_q.size() == 0) begin
          $error("result transfer with nothing expected: side %0d price %0h qty %0h",
                 out_side_i, out_price_i, out_qty_i);
          fail_cnt_o++;
        end else begin
          want = expected_q.pop_front();
          check_field("out_side", want.side, out_side_i);
          check_field("out_price", want.price, out_price_i);
          check_field("out_qty", want.qty, out_qty_i);
          check_field("level_valid", want.level_valid, level_valid_i);
          check_field("book_valid", want.book_valid, book_valid_i);
          check_field("cur_update_id", want.update_id, cur_update_id_i);
          check_field("overflow", want.overflow, overflow_i);
          check_field("last_result", want.last_result, last_result_i);
        end
      end
      if (in_valid_i && in_ready_i) apply_command();
    end
    pending_o = expected_q.size();
  end

endmodule

[tb/sv/order_book_price_levels_top_tb.sv]
module order_book_price_levels_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import obpl_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    mode_e                 mode;
    logic                  side;
    logic [PRICE_BITS-1:0] price;
    logic [QTY_BITS-1:0]   qty;
    logic                  is_first;
    logic                  is_last;
    logic [UID_W-1:0]      uid;
    logic [RC_W-1:0]       rc;
  } book_cmd_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [1:0]            mode_i;
  logic                  side_i;
  logic [PRICE_BITS-1:0] price_i;
  logic [QTY_BITS-1:0]   qty_i;
  logic                  first_i;
  logic                  last_i;
  logic [UID_W-1:0]      update_id_i;
  logic [RC_W-1:0]       read_count_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic                  out_side_o;
  logic [PRICE_BITS-1:0] out_price_o;
  logic [QTY_BITS-1:0]   out_qty_o;
  logic                  level_valid_o;
  logic                  book_valid_o;
  logic [UID_W-1:0]      cur_update_id_o;
  logic                  overflow_o;
  logic                  last_result_o;

  int fail_cnt;
  int pending;
  int checked;
  int idle_pct;
  int stall_pct;
  int cmds_sent;

  order_book_price_levels_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .mode_i          (mode_i),
    .side_i          (side_i),
    .price_i         (price_i),
    .qty_i           (qty_i),
    .first_i         (first_i),
    .last_i          (last_i),
    .update_id_i     (update_id_i),
    .read_count_i    (read_count_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_side_o      (out_side_o),
    .out_price_o     (out_price_o),
    .out_qty_o       (out_qty_o),
    .level_valid_o   (level_valid_o),
    .book_valid_o    (book_valid_o),
    .cur_update_id_o (cur_update_id_o),
    .overflow_o      (overflow_o),
    .last_result_o   (last_result_o)
  );

  order_book_price_levels_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .mode_i          (mode_i),
    .side_i          (side_i),
    .price_i         (price_i),
    .qty_i           (qty_i),
    .first_i         (first_i),
    .last_i          (last_i),
    .update_id_i     (update_id_i),
    .read_count_i    (read_count_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_side_i      (out_side_o),
    .out_price_i     (out_price_o),
    .out_qty_i       (out_qty_o),
    .level_valid_i   (level_valid_o),
    .book_valid_i    (book_valid_o),
    .cur_update_id_i (cur_update_id_o),
    .overflow_i      (overflow_o),
    .last_result_i   (last_result_o),
    .fail_cnt_o      (fail_cnt),
    .pending_o       (pending),
    .checked_o       (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("timeout after %0d cycles, %0d results still expected", CYCLE_LIMIT, pending);
    $display("CHECKS FAILED");
    $finish;
  end

  // receiver side backpressure
  initial begin
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic book_cmd_t make_cmd(mode_e m, logic s, logic [PRICE_BITS-1:0] p,
                                         logic [QTY_BITS-1:0] q, logic f, logic l,
                                         logic [UID_W-1:0] u, logic [RC_W-1:0] rc);
    book_cmd_t c;
    c.mode = m;
    c.side = s;
    c.price = p;
    c.qty = q;
    c.is_first = f;
    c.is_last = l;
    c.uid = u;
    c.rc = rc;
    return c;
  endfunction

  function automatic logic [PRICE_BITS-1:0] rand_price();
    int r;
    logic [63:0] w;
    r = $urandom_range(99);
    w = {$urandom, $urandom};
    if (r < 85) return PRICE_BITS'(1000 + $urandom_range(63));
    if (r < 95) return w[PRICE_BITS-1:0];
    return (r < 97) ? '0 : '1;
  endfunction

  function automatic logic [QTY_BITS-1:0] rand_qty();
    int r;
    logic [63:0] w;
    r = $urandom_range(99);
    w = {$urandom, $urandom};
    if (r < 15) return '0;
    if (r < 60) return QTY_BITS'($urandom_range(1, 1000));
    if (r < 97) return w[QTY_BITS-1:0];
    return '1;
  endfunction

  function automatic logic [UID_W-1:0] rand_uid();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[UID_W-1:0];
  endfunction

  function automatic logic [RC_W-1:0] rand_count();
    int r;
    r = $urandom_range(99);
    if (r < 30) return RC_W'($urandom_range(4));
    if (r < 70) return RC_W'($urandom_range(5, 32));
    return RC_W'($urandom_range(63));
  endfunction

  task automatic send_cmd(input book_cmd_t c);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    mode_i       <= c.mode;
    side_i       <= c.side;
    price_i      <= c.price;
    qty_i        <= c.qty;
    first_i      <= c.is_first;
    last_i       <= c.is_last;
    update_id_i  <= c.uid;
    read_count_i <= c.rc;
    do @(posedge clk_i); while (!in_ready_o);
    cmds_sent++;
  endtask

  // pref_side < 0 spreads levels over both sides
  task automatic snapshot_burst(int n, int pref_side);
    logic s;
    for (int i = 0; i < n; i++) begin
      s = (pref_side >= 0 && $urandom_range(9) != 0) ? pref_side[0] : $urandom_range(1);
      send_cmd(make_cmd(MODE_SNAP, s, rand_price(), rand_qty(), i == 0, i == n - 1,
                        rand_uid(), rand_count()));
    end
  endtask

  task automatic diff_burst(int n);
    for (int i = 0; i < n; i++)
      send_cmd(make_cmd(MODE_DIFF, $urandom_range(1), rand_price(), rand_qty(),
                        $urandom_range(1), i == n - 1, rand_uid(), rand_count()));
  endtask

  task automatic read_side();
    send_cmd(make_cmd(MODE_READ, $urandom_range(1), rand_price(), rand_qty(),
                      $urandom_range(1), $urandom_range(1), rand_uid(), rand_count()));
  endtask

  task automatic random_phase(int target);
    int start;
    int pick;
    start = cmds_sent;
    // overfill one side so eviction and drop both happen
    snapshot_burst($urandom_range(34, 40), $urandom_range(1));
    read_side();
    while (cmds_sent - start < target) begin
      pick = $urandom_range(99);
      if (pick < 18) begin
        snapshot_burst($urandom_range(1, 8), -1);
      end else if (pick < 58) begin
        diff_burst($urandom_range(1, 8));
      end else if (pick < 88) begin
        read_side();
      end else if (pick < 93) begin
        send_cmd(make_cmd(MODE_RESET, $urandom_range(1), rand_price(), rand_qty(),
                          $urandom_range(1), $urandom_range(1), rand_uid(), rand_count()));
        snapshot_burst($urandom_range(2, 10), -1);
      end else begin
        send_cmd(make_cmd(mode_e'($urandom_range(3)), $urandom_range(1), rand_price(),
                          rand_qty(), $urandom_range(1), $urandom_range(1), rand_uid(),
                          rand_count()));
      end
    end
  endtask

  initial begin
    idle_pct     = 0;
    stall_pct    = 0;
    cmds_sent    = 0;
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    mode_i       <= MODE_RESET;
    side_i       <= 1'b0;
    price_i      <= '0;
    qty_i        <= '0;
    first_i      <= 1'b0;
    last_i       <= 1'b0;
    update_id_i  <= '0;
    read_count_i <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed
    send_cmd(make_cmd(MODE_READ, 1'b0, '0, '0, 1'b0, 1'b0, '0, 6'd5));
    send_cmd(make_cmd(MODE_DIFF, 1'b0, 40'd100, 40'd5, 1'b0, 1'b1, 48'd7, '0));
    send_cmd(make_cmd(MODE_SNAP, 1'b0, '0, '1, 1'b1, 1'b0, '0, '0));
    send_cmd(make_cmd(MODE_SNAP, 1'b0, 40'd500, '0, 1'b0, 1'b0, '0, '0));
    send_cmd(make_cmd(MODE_SNAP, 1'b1, '1, 40'd1, 1'b0, 1'b0, '0, '0));
    send_cmd(make_cmd(MODE_SNAP, 1'b1, 40'd200, 40'd3, 1'b0, 1'b0, '0, '0));
    send_cmd(make_cmd(MODE_SNAP, 1'b0, 40'd300, 40'd9, 1'b0, 1'b1, '1, '0));
    send_cmd(make_cmd(MODE_DIFF, 1'b0, 40'd400, 40'd2, 1'b0, 1'b0, '0, '0));
    send_cmd(make_cmd(MODE_DIFF, 1'b0, 40'd300, 40'd11, 1'b0, 1'b0, '0, '0));
    send_cmd(make_cmd(MODE_DIFF, 1'b1, 40'd999, '0, 1'b0, 1'b0, '0, '0));
    send_cmd(make_cmd(MODE_DIFF, 1'b1, 40'd200, '0, 1'b0, 1'b1, 48'h123, '0));
    send_cmd(make_cmd(MODE_READ, 1'b0, '0, '0, 1'b0, 1'b0, '0, 6'd63));
    send_cmd(make_cmd(MODE_READ, 1'b1, '0, '0, 1'b0, 1'b0, '0, 6'd0));
    send_cmd(make_cmd(MODE_READ, 1'b1, '0, '0, 1'b0, 1'b0, '0, 6'd1));
    send_cmd(make_cmd(MODE_SNAP, 1'b1, 40'd50, 40'd4, 1'b1, 1'b0, '0, '0));
    send_cmd(make_cmd(MODE_READ, 1'b0, '0, '0, 1'b0, 1'b0, '0, 6'd32));
    send_cmd(make_cmd(MODE_DIFF, 1'b0, 40'd60, 40'd8, 1'b0, 1'b1, 48'h456, '0));
    send_cmd(make_cmd(MODE_READ, 1'b1, '0, '0, 1'b0, 1'b0, '0, 6'd32));
    send_cmd(make_cmd(MODE_RESET, 1'b0, '0, '0, 1'b0, 1'b0, '0, '0));
    send_cmd(make_cmd(MODE_READ, 1'b1, '0, '0, 1'b0, 1'b0, '0, 6'd32));
    send_cmd(make_cmd(MODE_DIFF, 1'b1, 40'd70, 40'd1, 1'b0, 1'b1, 48'd9, '0));

    // fill the bid side past depth: better prices evict, a worse one is dropped
    send_cmd(make_cmd(MODE_SNAP, 1'b0, 40'd100, 40'd1, 1'b1, 1'b0, '0, '0));
    for (int i = 1; i < DEPTH + 2; i++)
      send_cmd(make_cmd(MODE_SNAP, 1'b0, PRICE_BITS'(100 + 2 * i), QTY_BITS'(i + 1), 1'b0,
                        i == DEPTH + 1, 48'd77, '0));
    send_cmd(make_cmd(MODE_DIFF, 1'b0, 40'd1, 40'd5, 1'b0, 1'b0, '0, '0));
    send_cmd(make_cmd(MODE_DIFF, 1'b0, 40'd150, 40'd9, 1'b0, 1'b1, 48'd78, '0));
    send_cmd(make_cmd(MODE_READ, 1'b0, '0, '0, 1'b0, 1'b0, '0, 6'd32));

    // random, one phase per handshake pressure mix
    random_phase(45);
    idle_pct = 49;
    random_phase(45);
    idle_pct  = 0;
    stall_pct = 49;
    random_phase(45);
    idle_pct  = 16;
    stall_pct = 16;
    random_phase(45);
    stall_pct = 0;

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("sent %0d commands across four pressure phases, %0d result transfers checked",
             cmds_sent, checked);
    if (fail_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", fail_cnt);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[files.f]
hdl/obpl_pkg.sv
hdl/obpl_cell.sv
hdl/obpl_side.sv
hdl/order_book_price_levels_top.sv
tb/sv/order_book_price_levels_checker.sv
tb/sv/order_book_price_levels_top_tb.sv
